// File: rtl/core/blsr_pkg.sv
// Shared widths, register indexes and controller/datapath interface types
// for the limb-stream remainder block. No dependencies.
package blsr_pkg;

	localparam int LimbW  = 32;
	localparam int ModW   = 31;
	localparam int AccW   = 64;
	localparam int DecW   = 27;
	localparam int CntW   = 5;   // 32 radix-4 steps cover the 64-bit dividend
	localparam int IdxW   = 1;

	localparam logic [DecW-1:0] DecimalBase = 27'd100000000;
	localparam logic [CntW-1:0] CntLast     = 5'd31;

	localparam logic [IdxW-1:0] REG_MODULUS       = 1'b0;
	localparam logic [IdxW-1:0] REG_DECIMAL_LIMBS = 1'b1;

	typedef struct packed {
		logic load;     // capture limb, modulus, base
		logic mul;      // form r*B
		logic add;      // add limb, seed divider
		logic div;      // one radix-4 remainder step
		logic commit;   // write back r, or emit and clear on last
		logic last;
	} blsr_cmd_t;

	typedef struct packed {
		logic div_last;
	} blsr_sts_t;

endpackage

// File: rtl/core/bignum_limb_stream_remainder.sv
// Streaming remainder of a big integer, limbs most significant first.
// Each accepted limb passes multiply, add, the radix-4 remainder loop and commit;
// a new limb is taken only after the previous one commits.
// Reset (arst_n low, async): running remainder 0, modulus 1, binary limbs,
// no beat pending. Depends on blsr_pkg, blsr_ctrl, blsr_dp.
module bignum_limb_stream_remainder (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration writes: the user must make them only while idle, unenforced by the block
	input  logic                        cfg_we,
	input  logic [blsr_pkg::IdxW-1:0]   cfg_idx,
	input  logic [blsr_pkg::ModW-1:0]   cfg_wdata,
	// limb input channel
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [blsr_pkg::LimbW-1:0]  limb,
	input  logic                        final_limb,
	// remainder output channel
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [blsr_pkg::ModW-1:0]   remainder
);
	import blsr_pkg::*;

	logic [ModW-1:0] modulus_q;
	logic            decimal_limbs_q;
	blsr_cmd_t       cmd;
	blsr_sts_t       sts;

	// Config registers. A zero modulus is mapped to 1 in the datapath.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q       <= ModW'(1);
			decimal_limbs_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_MODULUS:       modulus_q       <= cfg_wdata;
				REG_DECIMAL_LIMBS: decimal_limbs_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Controller: one limb in flight; the output register lets the next limb
	// start while a finished remainder beat waits.
	blsr_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.final_limb (final_limb),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.cmd        (cmd),
		.sts        (sts)
	);

	// Datapath: r*B (shift or 31x27 multiply), add limb, 2 bits per cycle of
	// restoring remainder over the 64-bit sum.
	blsr_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.limb          (limb),
		.modulus       (modulus_q),
		.decimal_limbs (decimal_limbs_q),
		.remainder     (remainder)
	);

endmodule

// File: rtl/core/blsr_ctrl.sv
// Sequencer for the limb-stream remainder block: input/output handshake
// and datapath commands. Depends on blsr_pkg.
module blsr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              final_limb,
	output logic              out_valid,
	input  logic              out_ready,
	output blsr_pkg::blsr_cmd_t cmd,
	input  blsr_pkg::blsr_sts_t sts
);
	import blsr_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_ADD  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0] state_q, state_d;
	logic       last_q;
	logic       out_valid_q;
	logic       slot_free;
	logic       do_commit;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign slot_free = !out_valid_q || out_ready;
	assign do_commit = (state_q == ST_DONE) && (!last_q || slot_free);

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		cmd.last   = last_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_ADD;
			end
			ST_ADD: begin
				cmd.add = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div = 1'b1;
				if (sts.div_last) state_d = ST_DONE;
			end
			ST_DONE: begin
				// last limb waits for a free output slot
				if (do_commit) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) last_q <= final_limb;
			if (do_commit && last_q) out_valid_q <= 1'b1;
			else if (out_ready)      out_valid_q <= 1'b0;
		end
	end

endmodule

// File: rtl/core/blsr_dp.sv
// Datapath: r*B + limb, then a radix-4 restoring remainder loop.
// Holds the running remainder and the output beat register. Depends on blsr_pkg.
module blsr_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  blsr_pkg::blsr_cmd_t         cmd,
	output blsr_pkg::blsr_sts_t         sts,
	input  logic [blsr_pkg::LimbW-1:0]  limb,
	input  logic [blsr_pkg::ModW-1:0]   modulus,
	input  logic                        decimal_limbs,
	output logic [blsr_pkg::ModW-1:0]   remainder
);
	import blsr_pkg::*;

	logic [LimbW-1:0] limb_q;
	logic [ModW-1:0]  mod_q;
	logic             dec_q;
	logic [ModW-1:0]  run_q;
	logic [AccW-1:0]  prod_q;
	logic [AccW-1:0]  acc_q;
	logic [ModW-1:0]  part_q;
	logic [CntW-1:0]  cnt_q;
	logic [ModW-1:0]  rem_q;
	logic [57:0]      dec_prod;
	logic [ModW-1:0]  step1, step2;

	// one restoring step: shift in a bit, subtract m if it fits
	function automatic logic [ModW-1:0] rem_step(input logic [ModW-1:0] p,
		input logic b, input logic [ModW-1:0] m);
		logic [ModW:0] t;
		t = {p, b};
		if (t >= {1'b0, m}) t = t - {1'b0, m};
		return t[ModW-1:0];
	endfunction

	assign dec_prod  = {27'd0, run_q} * {31'd0, DecimalBase};
	assign step1     = rem_step(part_q, acc_q[AccW-1], mod_q);
	assign step2     = rem_step(step1, acc_q[AccW-2], mod_q);
	assign sts.div_last = (cnt_q == CntLast);
	assign remainder = rem_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			limb_q <= limb;
			mod_q  <= (modulus == '0) ? ModW'(1) : modulus;
			dec_q  <= decimal_limbs;
		end
		if (cmd.mul) prod_q <= dec_q ? {6'd0, dec_prod} : {1'b0, run_q, 32'd0};
		if (cmd.add) begin
			acc_q  <= prod_q + {32'd0, limb_q};
			part_q <= '0;
			cnt_q  <= '0;
		end else if (cmd.div) begin
			acc_q  <= {acc_q[AccW-3:0], 2'b00};
			part_q <= step2;
			cnt_q  <= cnt_q + CntW'(1);
		end
		if (cmd.commit && cmd.last) rem_q <= part_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= '0;
		end else if (cmd.commit) begin
			run_q <= cmd.last ? '0 : part_q;
		end
	end

endmodule

// File: rtl/core/blsr_checker.sv
// Port-level checks for bignum_limb_stream_remainder, attached by bind.
// Depends on blsr_pkg.
module blsr_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [blsr_pkg::ModW-1:0]   remainder
);

	// a waiting result beat stays up
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("out_valid dropped before beat taken");

	// a waiting result beat keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(remainder))
		else $error("remainder changed while beat pending");

	// one limb at a time: busy right after an accepted beat
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("in_ready high right after accept");

	// a result cannot appear in the cycle after a limb is taken
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result too early after accept");

	// a result appears only as the block returns to idle
	a_rise_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result raised while busy");

endmodule

bind bignum_limb_stream_remainder blsr_checker u_chk (.*);

// File: dv/tb_bignum_limb_stream_remainder.sv
// Self-checking testbench for bignum_limb_stream_remainder: limb beats in,
// remainders out, checked against an in-bench remainder predictor.
// Depends on blsr_pkg and the RTL of the block.
module tb_bignum_limb_stream_remainder;
	timeunit 1ns;
	timeprecision 1ps;

	import blsr_pkg::*;

	localparam int ClkHalf  = 2;
	localparam int Settle   = 45;    // covers a non-final limb's divide plus a margin
	localparam int Watchdog = 1000;  // cycles with no beat on either side
	localparam int Target   = 1750;  // limbs in the random part

	typedef struct {
		logic [LimbW-1:0] value;
		logic             closes;
	} limb_beat_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [IdxW-1:0]  cfg_idx = '0;
	logic [ModW-1:0]  cfg_wdata = '0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic [LimbW-1:0] limb = '0;
	logic             final_limb = 1'b0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [ModW-1:0]  remainder;

	bignum_limb_stream_remainder DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.limb       (limb),
		.final_limb (final_limb),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.remainder  (remainder)
	);

	// predictor state: register copies and the running remainder
	logic [ModW-1:0] model_mod = 31'd1;
	logic            model_dec = 1'b0;
	logic [ModW-1:0] run_rem = '0;

	limb_beat_t      limb_queue[$];     // beats waiting for the driver
	logic [ModW-1:0] due_remainders[$]; // predicted, not yet seen on the output

	// handshake flags, sampled at the rising edge, read at the falling edge
	bit limb_taken;
	bit out_taken;
	bit no_idle;

	int send_gap;
	int ready_wait;
	bit wait_armed;
	int quiet_cycles;
	int bad_count;
	int limbs_taken;
	int remainders_checked;
	int limbs_queued;
	int settings_used;

	limb_beat_t      next_beat;
	logic [ModW-1:0] folded;
	logic [ModW-1:0] want;

	initial begin
		forever #(ClkHalf) clk = ~clk;
	end

	// One Horner step: (r*B + limb) mod m, where a zero modulus acts as 1.
	function automatic logic [ModW-1:0] fold_limb(logic [ModW-1:0] r, logic [LimbW-1:0] v,
			logic [ModW-1:0] m, logic dec);
		logic [63:0] acc;
		logic [63:0] div;
		div = (m == '0) ? 64'd1 : {33'd0, m};
		if (dec)
			acc = {33'd0, r} * 64'd100000000 + {32'd0, v};
		else
			acc = {1'b0, r, v};
		return ModW'(acc % div);
	endfunction

	//--------------------------------------------------------------------
	// Driver: presents queued limb beats, holds each until taken, and
	// inserts random idle gaps between beats unless the phase runs without idling.
	//--------------------------------------------------------------------
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !limb_taken) begin
			// beat still pending, hold payload
		end else if (send_gap > 0) begin
			in_valid <= 1'b0;
			send_gap--;
		end else if (limb_queue.size() > 0) begin
			next_beat = limb_queue.pop_front();
			in_valid <= 1'b1;
			limb <= next_beat.value;
			final_limb <= next_beat.closes;
			send_gap = no_idle ? 0 : $urandom_range(0, 5);
		end else begin
			in_valid <= 1'b0;
		end
	end

	//--------------------------------------------------------------------
	// Receiver: once a remainder shows up, stall it at random; while nothing
	// is offered, ready wanders at random. A phase without idling never stalls.
	//--------------------------------------------------------------------
	always @(negedge clk) begin
		if (out_taken)
			wait_armed = 1'b0;
		if (out_valid && !wait_armed) begin
			wait_armed = 1'b1;
			ready_wait = no_idle ? 0 : $urandom_range(0, 5);
		end
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (wait_armed) begin
			out_ready <= (ready_wait == 0);
			if (ready_wait > 0)
				ready_wait--;
		end else begin
			out_ready <= no_idle ? 1'b1 : 1'($urandom_range(0, 1));
		end
	end

	//--------------------------------------------------------------------
	// Monitor: predicts on every limb beat, checks every remainder beat,
	// and ends the run if the channels go quiet for too long.
	//--------------------------------------------------------------------
	always @(posedge clk) begin
		limb_taken = 1'b0;
		out_taken = 1'b0;
		if (arst_n) begin
			limb_taken = in_valid && in_ready;
			out_taken = out_valid && out_ready;
			if (limb_taken) begin
				folded = fold_limb(run_rem, limb, model_mod, model_dec);
				limbs_taken++;
				if (final_limb) begin
					due_remainders.push_back(folded);
					run_rem = '0;
				end else begin
					run_rem = folded;
				end
			end
			if (out_taken) begin
				if (due_remainders.size() == 0) begin
					$display("%0t: remainder beat with nothing expected, got %0d",
						$realtime, remainder);
					bad_count++;
				end else begin
					want = due_remainders.pop_front();
					remainders_checked++;
					if (remainder !== want) begin
						$display("%0t: remainder mismatch, expected %0d got %0d",
							$realtime, want, remainder);
						bad_count++;
					end
				end
			end
			if (limb_taken || out_taken) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= Watchdog) begin
					$display("%0t: no beat for %0d cycles, %0d remainders outstanding",
						$realtime, Watchdog, due_remainders.size());
					$display("bignum_limb_stream_remainder regression: fail");
					$finish;
				end
			end
		end
	end

	//--------------------------------------------------------------------
	// Stimulus helpers
	//--------------------------------------------------------------------

	// Register write at a falling edge; the predictor copy follows at once,
	// which is safe because writes happen only with the block idle.
	task automatic write_reg(logic [IdxW-1:0] idx, logic [ModW-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= value;
		if (idx == REG_MODULUS)
			model_mod = value;
		else
			model_dec = value[0];
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic push_limb(logic [LimbW-1:0] value, logic closes);
		limb_beat_t b;
		b.value = value;
		b.closes = closes;
		limb_queue.push_back(b);
		limbs_queued++;
	endtask

	// Wait until every beat is taken and every remainder checked, then let
	// a possible non-final limb finish its divide before touching registers.
	// Polled at the rising edge, where the driver's updates have settled.
	task automatic drain();
		do
			@(posedge clk);
		while (limb_queue.size() != 0 || in_valid || due_remainders.size() != 0);
		repeat (Settle) @(negedge clk);
		settings_used++;
	endtask

	function automatic logic [LimbW-1:0] rand_limb();
		int pick;
		pick = $urandom_range(0, 9);
		if (model_dec) begin
			if (pick < 8)
				return $urandom_range(0, 99999999);
			else if (pick == 8)
				return ($urandom_range(0, 1) != 0) ? 32'd99999999 : 32'd0;
			else
				return $urandom; // out-of-range decimal limb, taken in full
		end
		if (pick < 7)
			return $urandom;
		case ($urandom_range(0, 3))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return 32'h8000_0000;
			default: return 32'd1;
		endcase
	endfunction

	function automatic logic [ModW-1:0] rand_modulus();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return 31'd1;
			2: return 31'h7FFF_FFFF;
			3: return 31'd2;
			4: return ModW'(1) << $urandom_range(0, 30);
			5: return ModW'($urandom_range(1, 1000));
			default: return ModW'($urandom_range(1, 32'h7FFF_FFFF));
		endcase
	endfunction

	//--------------------------------------------------------------------
	// Test sequence
	//--------------------------------------------------------------------
	initial begin
		int budget;
		int n;
		bit leave_open;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: modulus 1, binary limbs, so everything folds to 0.
		push_limb(32'hFFFF_FFFF, 1'b1);
		drain();

		// Largest modulus, binary limbs, extreme limb values.
		write_reg(REG_MODULUS, 31'h7FFF_FFFF);
		write_reg(REG_DECIMAL_LIMBS, 31'd0);
		push_limb(32'hFFFF_FFFF, 1'b0);
		push_limb(32'hFFFF_FFFF, 1'b0);
		push_limb(32'hFFFF_FFFF, 1'b1);
		push_limb(32'd0, 1'b1);
		push_limb(32'hFFFF_FFFF, 1'b1);
		drain();

		// Decimal limbs, in range and then too large for base 10^8.
		write_reg(REG_DECIMAL_LIMBS, 31'h7FFF_FFFF);
		push_limb(32'd99999999, 1'b0);
		push_limb(32'd99999999, 1'b1);
		push_limb(32'hFFFF_FFFF, 1'b0);
		push_limb(32'hFFFF_FFFF, 1'b1);
		drain();

		// Zero modulus behaves as 1.
		write_reg(REG_MODULUS, '0);
		push_limb(32'd12345, 1'b0);
		push_limb(32'hFFFF_FFFF, 1'b1);
		drain();

		// Modulus and base change in the middle of a number.
		write_reg(REG_MODULUS, 31'd1000003);
		write_reg(REG_DECIMAL_LIMBS, 31'd0);
		push_limb(32'hFFFF_FFFF, 1'b0);
		push_limb(32'hDEAD_BEEF, 1'b0);
		drain();
		write_reg(REG_MODULUS, 31'd97);
		write_reg(REG_DECIMAL_LIMBS, 31'd1);
		push_limb(32'd5, 1'b1);
		push_limb(32'd0, 1'b1);
		drain();

		// Random phases: new settings, a batch of numbers, and now and then
		// a number left open so the next settings apply mid-number.
		limbs_queued = 0;
		while (limbs_queued < Target) begin
			if ($urandom_range(0, 3) != 0)
				write_reg(REG_MODULUS, rand_modulus());
			if ($urandom_range(0, 1) != 0)
				write_reg(REG_DECIMAL_LIMBS, ModW'($urandom));
			no_idle = ($urandom_range(0, 3) == 0);
			budget = $urandom_range(40, 160);
			while (budget > 0) begin
				n = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 6)
					: $urandom_range(7, 20);
				leave_open = (n >= budget) && ($urandom_range(0, 2) == 0);
				for (int i = 0; i < n; i++)
					push_limb(rand_limb(), (i == n - 1) && !leave_open);
				budget -= n;
			end
			drain();
		end

		// Close any number still open so nothing is left unchecked.
		no_idle = 1'b0;
		push_limb(rand_limb(), 1'b1);
		drain();

		$display("Covered %0d limb beats and %0d checked remainders over %0d settings phases.",
			limbs_taken, remainders_checked, settings_used);
		if (bad_count == 0 && due_remainders.size() == 0) begin
			$display("bignum_limb_stream_remainder regression: pass");
		end else begin
			$display("bignum_limb_stream_remainder regression: fail");
		end
		$finish;
	end

endmodule
